// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/dht_pwd_pkg.sv -----
// Shared types and constants for the single-wire sensor pulse-width decoder.
// No dependencies; used by the decoder, the checker and the testbench.
package dht_pwd_pkg;

  // Field widths of the result word, the config port and the elapsed time
  localparam int FRAME_OUT_W = 40;
  localparam int BITS_OUT_W  = 6;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;
  localparam int TIME_W      = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_GAP_MIN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_HIGH_MAX  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_HIGH_MIN  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_MIN  = 8'd3;

  // Register values after reset, in microseconds
  localparam logic [CFG_DATA_W-1:0] START_GAP_MIN_RST = 8'd40;
  localparam logic [CFG_DATA_W-1:0] BIT_HIGH_MAX_RST  = 8'd80;
  localparam logic [CFG_DATA_W-1:0] BIT_HIGH_MIN_RST  = 8'd15;
  localparam logic [CFG_DATA_W-1:0] ONE_HIGH_MIN_RST  = 8'd60;

  // Input command codes
  localparam logic CMD_CLEAR = 1'b0;
  localparam logic CMD_EDGE  = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic              line_level;
    logic [TIME_W-1:0] elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic [FRAME_OUT_W-1:0] frame_bytes;
    logic [BITS_OUT_W-1:0]  bits_taken;
    logic                   frame_complete;
    logic                   checksum_ok;
    logic                   sync_seen;
  } out_word_t;

endpackage

// ----- hdl/dht_pwd_csum.sv -----
// Frame checksum: sum of all bytes but the last against the nonzero last byte.
// Depends on nothing but its parameter; instantiated by the decoder top level.
module dht_pwd_csum #(
  parameter int FRAME_BYTES = 5
) (
  input  logic [FRAME_BYTES*8-1:0] frame,
  output logic                     ok
);

  localparam int SumW = $clog2((FRAME_BYTES - 1) * 255 + 1);

  logic [SumW-1:0] sum;
  logic [7:0]      last;

  // Add the leading bytes, byte 0 sits at the top of the frame
  always_comb begin
    sum = '0;
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      sum = sum + SumW'(frame[8*(FRAME_BYTES-1-k) +: 8]);
    end
  end

  assign last = frame[7:0];
  assign ok   = (sum == SumW'(last)) && (last != 8'd0);

endmodule

// ----- hdl/dht11_pulse_width_decoder.sv -----
// Channel  | signals                          | word
// ---------+----------------------------------+-------------------------------
// item     | item_valid, item_ready, item     | cmd, line level, elapsed time
// res      | res_valid, res_ready, res        | frame, bit count, flags
// cfg      | cfg_valid, cfg_ready, cfg_index, | timing thresholds, one per
//          | cfg_data                         | index, unknown indexes dropped
//
// Each edge word is decoded and its result registered at the
// accepting edge, so a new word is taken every cycle while res is drained.
// The single result register sets the rate; item_ready drops while a result
// waits and res_ready is low, and during reset. Synchronous reset clears sync,
// the bit counter and the frame and loads the default thresholds; cfg_ready
// is high outside reset.
// Depends on dht_pwd_pkg and dht_pwd_csum.
module dht11_pulse_width_decoder
  import dht_pwd_pkg::*;
#(
  parameter int FRAME_BYTES = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  in_word_t              item,
  output logic                  res_valid,
  input  logic                  res_ready,
  output out_word_t             res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int FrameW = FRAME_BYTES * 8;
  localparam int CntW   = $clog2(FrameW + 1);
  localparam int IdxW   = $clog2(FrameW);
  localparam int WideW  = (FrameW > FRAME_OUT_W) ? FrameW : FRAME_OUT_W;

  // Thresholds
  logic [CFG_DATA_W-1:0] start_gap_min;
  logic [CFG_DATA_W-1:0] bit_high_max;
  logic [CFG_DATA_W-1:0] bit_high_min;
  logic [CFG_DATA_W-1:0] one_high_min;

  // Decoder state
  logic              sync;
  logic [CntW-1:0]   bit_cnt;
  logic [FrameW-1:0] frame;

  logic              sync_next;
  logic [CntW-1:0]   bit_cnt_next;
  logic [FrameW-1:0] frame_next;
  logic [WideW-1:0]  frame_wide;
  logic [IdxW-1:0]   set_idx;
  logic [TIME_W-1:0] dt;
  logic              full;
  logic              in_window;
  logic              take;
  logic              is_one;
  logic              csum_ok;
  logic              accept;

  assign accept     = item_valid && item_ready;
  assign item_ready = !rst && (!res_valid || res_ready);
  assign cfg_ready  = !rst;

  // Classify the edge against the thresholds
  assign dt        = item.elapsed_us;
  assign full      = (bit_cnt == CntW'(FrameW));
  assign in_window = (dt <= TIME_W'(bit_high_max)) && (dt >= TIME_W'(bit_high_min));
  assign take      = (item.cmd == CMD_EDGE) && !item.line_level && sync && in_window && !full;
  assign is_one    = dt > TIME_W'(one_high_min);
  assign set_idx   = IdxW'(FrameW - 1) - bit_cnt[IdxW-1:0];

  // Next state: clear on command, set sync on a long gap, shift in a bit
  always_comb begin
    sync_next    = sync;
    bit_cnt_next = bit_cnt;
    frame_next   = frame;
    if (item.cmd == CMD_CLEAR) begin
      sync_next    = 1'b0;
      bit_cnt_next = '0;
      frame_next   = '0;
    end else if (item.line_level) begin
      if (dt > TIME_W'(start_gap_min)) begin
        sync_next = 1'b1;
      end
    end else if (take) begin
      bit_cnt_next = bit_cnt + CntW'(1);
      if (is_one) begin
        frame_next[set_idx] = 1'b1;
      end
    end
  end

  dht_pwd_csum #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_csum (
    .frame(frame_next),
    .ok   (csum_ok)
  );

  assign frame_wide = WideW'(frame_next);

  // Hold thresholds and state, register the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      start_gap_min <= START_GAP_MIN_RST;
      bit_high_max  <= BIT_HIGH_MAX_RST;
      bit_high_min  <= BIT_HIGH_MIN_RST;
      one_high_min  <= ONE_HIGH_MIN_RST;
      sync          <= 1'b0;
      bit_cnt       <= '0;
      frame         <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_START_GAP_MIN) begin
          start_gap_min <= cfg_data;
        end
        if (cfg_index == REG_BIT_HIGH_MAX) begin
          bit_high_max <= cfg_data;
        end
        if (cfg_index == REG_BIT_HIGH_MIN) begin
          bit_high_min <= cfg_data;
        end
        if (cfg_index == REG_ONE_HIGH_MIN) begin
          one_high_min <= cfg_data;
        end
      end
      if (accept) begin
        sync      <= sync_next;
        bit_cnt   <= bit_cnt_next;
        frame     <= frame_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res.frame_bytes    <= frame_wide[FRAME_OUT_W-1:0];
      res.bits_taken     <= BITS_OUT_W'(bit_cnt_next);
      res.frame_complete <= (bit_cnt_next == CntW'(FrameW));
      res.checksum_ok    <= csum_ok;
      res.sync_seen      <= sync_next;
    end
  end

endmodule

// ----- hdl/dht_pwd_chk.sv -----
// Port-level checker for the pulse-width decoder, bound to the top level.
// Depends on dht_pwd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dht_pwd_chk
  import dht_pwd_pkg::*;
#(
  parameter int FRAME_BYTES = 5
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  item_valid,
  input logic                  item_ready,
  input in_word_t              item,
  input logic                  res_valid,
  input logic                  res_ready,
  input out_word_t             res
);

  localparam logic [BITS_OUT_W-1:0] FullCount = BITS_OUT_W'(FRAME_BYTES * 8);

  // A stalled result holds its word
  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

  // A clear command yields an empty, unsynced result next cycle
  `ASSERT_NEXT(a_clear_result, clk, rst, item_valid && item_ready && (item.cmd == CMD_CLEAR),
    res_valid && !res.sync_seen && (res.bits_taken == '0) && (res.frame_bytes == '0))

  // Completion reports the full bit count
  `ASSERT_SAME(a_complete_count, clk, rst, res_valid && res.frame_complete,
    res.bits_taken == FullCount)

  // A good checksum never comes from a zero last byte
  `ASSERT_SAME(a_csum_nonzero, clk, rst, res_valid && res.checksum_ok,
    res.frame_bytes[7:0] != 8'd0)

endmodule

bind dht11_pulse_width_decoder dht_pwd_chk #(
  .FRAME_BYTES(FRAME_BYTES)
) u_dht_pwd_chk (
  .clk       (clk),
  .rst       (rst),
  .item_valid(item_valid),
  .item_ready(item_ready),
  .item      (item),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res)
);

// ----- verif/tb_dht11_pulse_width_decoder.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for dht11_pulse_width_decoder: edge words and threshold
// writes go in, every result word is predicted in the bench, or read by hand for typed rows, and checked per field.
// Depends on dht_pwd_pkg and the decoder RTL.
module tb_dht11_pulse_width_decoder;
  import dht_pwd_pkg::*;

  localparam int FRAME_LEN   = 5;
  localparam int FRAME_W     = FRAME_LEN * 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t result;
  } probe_row_t;

  typedef struct packed {
    logic [7:0]  gap;
    logic [7:0]  high_max;
    logic [7:0]  high_min;
    logic [7:0]  one_min;
    logic [7:0]  send_idle;
    logic [7:0]  recv_stall;
    logic [15:0] count;
    logic        hold;
  } phase_t;

  localparam out_word_t CLEARED   = '0;
  localparam out_word_t SYNC_ONLY = '{40'h0, 6'd0, 1'b0, 1'b0, 1'b1};

  // Directed words at reset thresholds; typed rows carry a hand-read result
  localparam probe_row_t PROBES [17] = '{
    '{'{CMD_CLEAR, 1'b0, 16'd0},     1'b1, CLEARED},
    '{'{CMD_EDGE,  1'b0, 16'd50},    1'b1, CLEARED},
    '{'{CMD_EDGE,  1'b1, 16'd40},    1'b1, CLEARED},
    '{'{CMD_EDGE,  1'b1, 16'd41},    1'b1, SYNC_ONLY},
    '{'{CMD_EDGE,  1'b0, 16'd14},    1'b1, SYNC_ONLY},
    '{'{CMD_EDGE,  1'b0, 16'd81},    1'b1, SYNC_ONLY},
    '{'{CMD_EDGE,  1'b0, 16'd15},    1'b1, '{40'h0, 6'd1, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_EDGE,  1'b0, 16'd80},    1'b1, '{40'h40_0000_0000, 6'd2, 1'b0, 1'b0, 1'b1}},
    '{'{CMD_EDGE,  1'b0, 16'd60},    1'b0, CLEARED},
    '{'{CMD_EDGE,  1'b0, 16'd61},    1'b0, CLEARED},
    '{'{CMD_EDGE,  1'b1, 16'hFFFF},  1'b0, CLEARED},
    '{'{CMD_EDGE,  1'b0, 16'hFFFF},  1'b0, CLEARED},
    '{'{CMD_EDGE,  1'b0, 16'd0},     1'b0, CLEARED},
    '{'{CMD_CLEAR, 1'b1, 16'hFFFF},  1'b1, CLEARED},
    '{'{CMD_EDGE,  1'b0, 16'd30},    1'b1, CLEARED},
    '{'{CMD_EDGE,  1'b1, 16'd0},     1'b1, CLEARED},
    '{'{CMD_EDGE,  1'b1, 16'd41},    1'b1, SYNC_ONLY}
  };

  // Threshold settings and handshake pressure, one row per random phase
  localparam phase_t PHASES [7] = '{
    '{8'd40,  8'd80,  8'd15,  8'd60,  8'd0,  8'd0,  16'd60,  1'b1},
    '{8'd0,   8'd255, 8'd0,   8'd255, 8'd75, 8'd0,  16'd50,  1'b0},
    '{8'd255, 8'd255, 8'd0,   8'd0,   8'd0,  8'd75, 16'd50,  1'b0},
    '{8'd20,  8'd100, 8'd30,  8'd64,  8'd22, 8'd22, 16'd50,  1'b0},
    '{8'd100, 8'd10,  8'd50,  8'd5,   8'd0,  8'd0,  16'd35,  1'b1},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd22, 8'd22, 16'd35,  1'b0},
    '{8'd40,  8'd80,  8'd15,  8'd60,  8'd0,  8'd0,  16'd80,  1'b0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  item_valid = 1'b0;
  logic                  item_ready;
  in_word_t              item = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  out_word_t             res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Bench copy of the thresholds and the frame state
  logic [7:0]         gap_min_us;
  logic [7:0]         high_max_us;
  logic [7:0]         high_min_us;
  logic [7:0]         one_min_us;
  logic               synced;
  int                 bit_idx;
  int                 byte_idx;
  logic [FRAME_W-1:0] frame;

  out_word_t decoded_words [$];
  out_word_t want;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_requests = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  dht11_pulse_width_decoder #(.FRAME_BYTES(FRAME_LEN)) DUT (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the bench frame state by one edge word and return the result word
  function automatic out_word_t decode_edge(in_word_t w);
    out_word_t  r;
    logic [9:0] byte_sum;
    int         k;
    byte_sum = '0;
    if (w.cmd == CMD_CLEAR) begin
      synced   = 1'b0;
      bit_idx  = 0;
      byte_idx = 0;
      frame    = '0;
    end else if (w.line_level) begin
      if (w.elapsed_us > gap_min_us) synced = 1'b1;
    end else if (synced && byte_idx < FRAME_LEN &&
                 w.elapsed_us <= high_max_us && w.elapsed_us >= high_min_us) begin
      // MSB first within each byte, byte 0 on top
      if (w.elapsed_us > one_min_us) frame[8 * (FRAME_LEN - 1 - byte_idx) + 7 - bit_idx] = 1'b1;
      bit_idx++;
      if (bit_idx == 8) begin
        bit_idx = 0;
        byte_idx++;
      end
    end
    for (k = 0; k < FRAME_LEN - 1; k++) byte_sum += 10'(frame[8 * (FRAME_LEN - 1 - k) +: 8]);
    r.frame_bytes    = frame;
    r.bits_taken     = BITS_OUT_W'(byte_idx * 8 + bit_idx);
    r.frame_complete = (byte_idx >= FRAME_LEN);
    r.checksum_ok    = (byte_sum == 10'(frame[7:0])) && (frame[7:0] != 8'd0);
    r.sync_seen      = synced;
    return r;
  endfunction

  function automatic in_word_t make_word(logic cmd, logic level, int unsigned us);
    in_word_t w;
    w.cmd        = cmd;
    w.line_level = level;
    w.elapsed_us = TIME_W'(us);
    return w;
  endfunction

  // High time that decodes to the wanted bit under the current window, if any does
  function automatic int unsigned pick_high_time(logic one);
    int lo;
    int hi;
    lo = int'(high_min_us);
    hi = int'(high_max_us);
    if (one && int'(one_min_us) + 1 > lo) lo = int'(one_min_us) + 1;
    if (!one && int'(one_min_us) < hi) hi = int'(one_min_us);
    if (lo > hi) return $urandom_range(300);
    return $urandom_range(hi, lo);
  endfunction

  // Offer one edge word, with a random idle gap first; valid stays up afterwards
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    item       <= w;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    decoded_words.push_back(decode_edge(w));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_START_GAP_MIN: gap_min_us  = data;
      REG_BIT_HIGH_MAX:  high_max_us = data;
      REG_BIT_HIGH_MIN:  high_min_us = data;
      REG_ONE_HIGH_MIN:  one_min_us  = data;
      default: ;
    endcase
  endtask

  // Drop valid and drain every pending result word
  task automatic settle();
    item_valid <= 1'b0;
    while (decoded_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(string field, logic [FRAME_OUT_W-1:0] want_v,
                               logic [FRAME_OUT_W-1:0] got);
    if (want_v !== got) begin
      $error("%s: expected %0h, actual %0h", field, want_v, got);
      mismatches++;
    end
  endtask

  // Check each accepted result word, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (decoded_words.size() == 0) begin
        $error("result word with nothing pending: %h", res);
        mismatches++;
      end else begin
        want = decoded_words.pop_front();
        compare_field("frame_bytes", want.frame_bytes, res.frame_bytes);
        compare_field("bits_taken", FRAME_OUT_W'(want.bits_taken),
                      FRAME_OUT_W'(res.bits_taken));
        compare_field("frame_complete", FRAME_OUT_W'(want.frame_complete),
                      FRAME_OUT_W'(res.frame_complete));
        compare_field("checksum_ok", FRAME_OUT_W'(want.checksum_ok),
                      FRAME_OUT_W'(res.checksum_ok));
        compare_field("sync_seen", FRAME_OUT_W'(want.sync_seen),
                      FRAME_OUT_W'(res.sync_seen));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    phase_t             ph;
    logic [FRAME_W-1:0] content;
    logic [9:0]         sum_acc;
    logic [7:0]         byte_val;
    int                 n_bits;
    int                 sent;
    int                 k;
    gap_min_us  = START_GAP_MIN_RST;
    high_max_us = BIT_HIGH_MAX_RST;
    high_min_us = BIT_HIGH_MIN_RST;
    one_min_us  = ONE_HIGH_MIN_RST;
    synced      = 1'b0;
    bit_idx     = 0;
    byte_idx    = 0;
    frame       = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table; pin the hand-read rows
    foreach (PROBES[i]) begin
      send_word(PROBES[i].word);
      if (PROBES[i].typed) decoded_words[decoded_words.size() - 1] = PROBES[i].result;
    end

    foreach (PHASES[p]) begin
      ph = PHASES[p];
      settle();
      write_reg(REG_START_GAP_MIN, ph.gap);
      write_reg(REG_BIT_HIGH_MAX, ph.high_max);
      write_reg(REG_BIT_HIGH_MIN, ph.high_min);
      write_reg(REG_ONE_HIGH_MIN, ph.one_min);
      // unknown index: must leave the thresholds alone
      write_reg(p == 0 ? REG_INDEX_TOP : CFG_IDX_W'(REG_ONE_HIGH_MIN + 1 + $urandom_range(251)),
                CFG_DATA_W'($urandom));
      cfg_valid <= 1'b0;
      send_idle_pct  = ph.send_idle;
      recv_stall_pct = ph.recv_stall;
      if (ph.hold) hold_requests++;
      sent = 0;
      while (sent < ph.count) begin
        if ($urandom_range(99) < 72) begin
          // Frame image: either a good checksum or random bytes
          if ($urandom_range(2) == 0) begin
            content = '0;
            sum_acc = '0;
            for (k = 0; k < FRAME_LEN - 1; k++) begin
              byte_val = 8'($urandom_range(63));
              content[8 * (FRAME_LEN - 1 - k) +: 8] = byte_val;
              sum_acc += 10'(byte_val);
            end
            content[7:0] = sum_acc[7:0];
          end else begin
            content = FRAME_W'({$urandom, $urandom});
          end
          if ($urandom_range(9) != 0) begin
            send_word(make_word(CMD_CLEAR, 1'($urandom), $urandom_range(65535)));
            sent++;
          end
          send_word(make_word(CMD_EDGE, 1'b1, ($urandom_range(7) == 0) ? 65535 :
                              gap_min_us + 1 + $urandom_range(100)));
          sent++;
          // Most frames run to full or past it; some break off early
          n_bits = ($urandom_range(4) == 0) ? $urandom_range(FRAME_W - 1)
                                            : FRAME_W + $urandom_range(3);
          for (k = 0; k < n_bits; k++) begin
            if ($urandom_range(3) == 0) begin
              send_word(make_word(CMD_EDGE, 1'b1, $urandom_range(80)));
              sent++;
            end
            send_word(make_word(CMD_EDGE, 1'b0, pick_high_time(
                k < FRAME_W ? content[FRAME_W - 1 - k] : 1'($urandom))));
            sent++;
          end
        end else begin
          // Noise burst with fully random fields
          repeat (1 + $urandom_range(9)) begin
            send_word(make_word(($urandom_range(3) != 0) ? CMD_EDGE : CMD_CLEAR,
                                1'($urandom), $urandom_range(65535)));
            sent++;
          end
        end
      end
    end

    settle();
    if (mismatches == 0 && decoded_words.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/dht_pwd_pkg.sv
hdl/dht_pwd_csum.sv
hdl/dht11_pulse_width_decoder.sv
hdl/dht_pwd_chk.sv
verif/tb_dht11_pulse_width_decoder.sv
